### rtl/wlcs_pkg.sv
// ----------------------------------------------------------------------------
// wlcs_pkg: shared types and constants for the weighted least-connections
// selector.
// ----------------------------------------------------------------------------
package wlcs_pkg;

  localparam int unsigned ActW    = 2;
  localparam int unsigned StatW   = 6;
  localparam int unsigned DepthW  = 8;
  localparam int unsigned WeightW = 10;
  localparam int unsigned CountW  = 16;
  localparam int unsigned LifeW   = 32;
  localparam int unsigned IdxOutW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 6;
  localparam int unsigned NumW    = 5;
  // (count+1)*1000 fits in 26 bits
  localparam int unsigned DividendW = 26;
  localparam int unsigned LoadW     = 26;

  localparam logic [WeightW-1:0] WeightReset = WeightW'(1000);
  localparam logic [StatW-1:0] StRunning = 6'h01;
  localparam logic [StatW-1:0] StMaster  = 6'h02;
  localparam logic [StatW-1:0] StSlave   = 6'h04;
  localparam logic [StatW-1:0] StMaint   = 6'h08;

  typedef enum logic [ActW-1:0] {
    ActLoad  = 2'd0,
    ActOpen  = 2'd1,
    ActClose = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMask  = 2'd0,
    CfgValue = 2'd1,
    CfgCount = 2'd2,
    CfgSpare = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StRoot,
    StScan,
    StDivI,
    StCmp,
    StCommit,
    StSimple,
    StOut
  } state_e;

endpackage

### rtl/weighted_least_conn_selector.sv
// ----------------------------------------------------------------------------
// weighted_least_conn_selector: server table with least-connections pick.
// Input transactions (valid/stall) carry load, open, close or no-op
// actions; each gives one output transaction with found, chosen index and
// current count. Open walks the table twice: entry by entry to find the
// root master, then per eligible entry one serial restoring division of
// (count+1)*1000 by the weight on a single shared divider. The load of the
// current best is kept in a register, so only one divide is needed per
// entry.
// The block takes one transaction at a time; stall_o stays high until the
// result has been taken. While the receiver stalls the result is held.
// Reset clears the table: counts zero, status zero, depth zero, weight
// 1000; filter mask and value are 1, server count 0. Config writes are
// taken at any time and must come only while idle.
// ----------------------------------------------------------------------------
module weighted_least_conn_selector #(
  parameter int unsigned MAX_SERVERS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [5:0]               cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic [3:0]               server_index_i,
  input  logic [5:0]               status_flags_i,
  input  logic [7:0]               replication_depth_i,
  input  logic [9:0]               weight_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic [3:0]               chosen_index_o,
  output logic [15:0]              connection_count_o
);
  import wlcs_pkg::*;

  localparam int unsigned IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CW = $clog2(MAX_SERVERS + 1);

  logic [CountW-1:0]  cur_q   [MAX_SERVERS];
  logic [LifeW-1:0]   life_q  [MAX_SERVERS];
  logic [StatW-1:0]   stat_q  [MAX_SERVERS];
  logic [DepthW-1:0]  dep_q   [MAX_SERVERS];
  logic [WeightW-1:0] wgt_q   [MAX_SERVERS];

  logic [CfgW-1:0] fmask_q, fval_q;
  logic [NumW-1:0] scount_q;

  state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] n_q, n_d;
  logic [StatW-1:0] mask_q, mask_d, val_q, val_d;
  logic          mfound_q, mfound_d;
  logic [IW-1:0] master_q, master_d;
  logic          cfound_q, cfound_d;
  logic [IW-1:0] cand_q, cand_d;
  logic [LoadW-1:0] cload_q, cload_d;
  logic [ActW-1:0] act_q, act_d;
  logic [3:0]    idx_q, idx_d;
  logic [StatW-1:0] ist_q, ist_d;
  logic [DepthW-1:0] idep_q, idep_d;
  logic [WeightW-1:0] iwgt_q, iwgt_d;
  logic          found_q, found_d;
  logic [3:0]    chosen_q, chosen_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  // shared serial divider
  logic [DividendW-1:0] dq_q, dq_d;
  logic [WeightW:0]     rem_q, rem_d;
  logic [4:0]           dstep_q, dstep_d;
  logic [WeightW+1:0]   trial;

  logic [IW-1:0] ii;
  logic [IW-1:0] sidx;
  logic          sidx_ok;
  logic [StatW-1:0] st_i;
  logic          elig;
  logic          wr_load, wr_close, wr_open;
  logic [IW-1:0] wr_idx;

  assign ii      = i_q[IW-1:0];
  assign sidx_ok = 32'(idx_q) < MAX_SERVERS;
  assign sidx    = IW'(idx_q);
  assign st_i    = stat_q[ii];
  assign elig    = ((st_i & StMaint) == '0) && (wgt_q[ii] != '0) &&
                   ((st_i & StRunning) != '0) && ((st_i & mask_q & val_q) != '0);
  assign trial   = {rem_q, dq_q[DividendW-1]} - {2'b00, wgt_q[ii]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmask_q  <= CfgW'(1);
      fval_q   <= CfgW'(1);
      scount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMask:  fmask_q  <= cfg_data_i;
        CfgValue: fval_q   <= cfg_data_i;
        CfgCount: scount_q <= cfg_data_i[NumW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_SERVERS; k++) begin
        cur_q[k]  <= '0;
        life_q[k] <= '0;
        stat_q[k] <= '0;
        dep_q[k]  <= '0;
        wgt_q[k]  <= WeightReset;
      end
    end else begin
      if (wr_load) begin
        stat_q[wr_idx] <= ist_q;
        dep_q[wr_idx]  <= idep_q;
        wgt_q[wr_idx]  <= iwgt_q;
      end
      if (wr_close && cur_q[wr_idx] != '0) begin
        cur_q[wr_idx] <= cur_q[wr_idx] - CountW'(1);
      end
      if (wr_open) begin
        if (cur_q[wr_idx] != '1) begin
          cur_q[wr_idx] <= cur_q[wr_idx] + CountW'(1);
        end
        life_q[wr_idx] <= life_q[wr_idx] + LifeW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; n_q <= n_d; mask_q <= mask_d; val_q <= val_d;
    mfound_q <= mfound_d; master_q <= master_d;
    cfound_q <= cfound_d; cand_q <= cand_d; cload_q <= cload_d;
    act_q <= act_d; idx_q <= idx_d; ist_q <= ist_d; idep_q <= idep_d;
    iwgt_q <= iwgt_d; found_q <= found_d; chosen_q <= chosen_d;
    cnt_q <= cnt_d; dq_q <= dq_d; rem_q <= rem_d; dstep_q <= dstep_d;
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q; n_d = n_q; mask_d = mask_q; val_d = val_q;
    mfound_d = mfound_q; master_d = master_q;
    cfound_d = cfound_q; cand_d = cand_q; cload_d = cload_q;
    act_d = act_q; idx_d = idx_q; ist_d = ist_q; idep_d = idep_q;
    iwgt_d = iwgt_q; found_d = found_q; chosen_d = chosen_q; cnt_d = cnt_q;
    dq_d = dq_q; rem_d = rem_q; dstep_d = dstep_q;
    wr_load = 1'b0; wr_close = 1'b0; wr_open = 1'b0;
    wr_idx = sidx;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          act_d = action_i; idx_d = server_index_i; ist_d = status_flags_i;
          idep_d = replication_depth_i; iwgt_d = weight_i;
          i_d = '0; mfound_d = 1'b0; cfound_d = 1'b0;
          n_d = (32'(scount_q) > MAX_SERVERS) ? CW'(MAX_SERVERS) : CW'(scount_q);
          if (fmask_q == '0 && fval_q == '0) begin
            mask_d = StRunning; val_d = StRunning;
          end else begin
            mask_d = fmask_q; val_d = fval_q;
          end
          state_d = (action_e'(action_i) == ActOpen) ? StRoot : StSimple;
        end
      end
      StRoot: begin
        if (i_q == n_q) begin
          i_d = '0;
          state_d = StScan;
        end else begin
          if ((st_i & (StMaster | StMaint)) == StMaster &&
              (!mfound_q || dep_q[ii] < dep_q[master_q])) begin
            mfound_d = 1'b1; master_d = ii;
          end
          i_d = i_q + CW'(1);
        end
      end
      StScan: begin
        if (i_q == n_q) begin
          state_d = StCommit;
        end else if (!elig) begin
          i_d = i_q + CW'(1);
        end else if (mfound_q && ii == master_q && (val_q & StSlave) != '0) begin
          i_d = i_q + CW'(1);
        end else if (mfound_q && ii == master_q && (val_q & StMaster) != '0) begin
          cfound_d = 1'b1; cand_d = master_q;
          state_d = StCommit;
        end else if (!mfound_q && (val_q & StMaster) != '0) begin
          cfound_d = 1'b0;
          state_d = StCommit;
        end else begin
          dq_d = DividendW'((32'(cur_q[ii]) + 32'd1) * 32'd1000);
          rem_d = '0; dstep_d = '0;
          state_d = StDivI;
        end
      end
      StDivI: begin
        if (!trial[WeightW+1]) begin
          rem_d = trial[WeightW:0];
          dq_d = {dq_q[DividendW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[WeightW-1:0], dq_q[DividendW-1]};
          dq_d = {dq_q[DividendW-2:0], 1'b0};
        end
        dstep_d = dstep_q + 5'd1;
        if (dstep_q == 5'(DividendW - 1)) state_d = StCmp;
      end
      StCmp: begin
        if (!cfound_q || dq_q < cload_q ||
            (dq_q == cload_q && life_q[ii] < life_q[cand_q])) begin
          cfound_d = 1'b1; cand_d = ii; cload_d = dq_q;
        end
        i_d = i_q + CW'(1);
        state_d = StScan;
      end
      StCommit: begin
        if (cfound_q || mfound_q) begin
          wr_idx = cfound_q ? cand_q : master_q;
          wr_open = 1'b1;
          found_d = 1'b1;
          chosen_d = IdxOutW'(wr_idx);
          cnt_d = (cur_q[wr_idx] != '1) ? cur_q[wr_idx] + CountW'(1) : cur_q[wr_idx];
        end else begin
          found_d = 1'b0; chosen_d = '0; cnt_d = '0;
        end
        state_d = StOut;
      end
      StSimple: begin
        found_d = 1'b0; chosen_d = idx_q; cnt_d = '0;
        if (sidx_ok) begin
          cnt_d = cur_q[sidx];
          unique case (action_e'(act_q))
            ActLoad: begin
              wr_load = 1'b1; found_d = 1'b1;
            end
            ActClose: begin
              wr_close = 1'b1; found_d = 1'b1;
              if (cur_q[sidx] != '0) cnt_d = cur_q[sidx] - CountW'(1);
            end
            default: ;
          endcase
        end
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o        = (state_q == StOut);
  assign found_o            = found_q;
  assign chosen_index_o     = chosen_q;
  assign connection_count_o = cnt_q;

endmodule

### rtl/wlcs_checker.sv
// ----------------------------------------------------------------------------
// wlcs_checker: port-level checks for the selector.
// ----------------------------------------------------------------------------
module wlcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        found_o,
  input logic [3:0]  chosen_index_o,
  input logic [15:0] connection_count_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(connection_count_o))
    else $error("output dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("accept not followed by work");
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(found_o) && $stable(chosen_index_o))
    else $error("result fields changed while stalled");
endmodule

bind weighted_least_conn_selector wlcs_checker u_wlcs_checker (.*);

### tb/wlcs_result_monitor.sv
// ----------------------------------------------------------------------------
// wlcs_result_monitor: server table tracker and result checker
// Follows register writes and accepted input transactions, keeps its own copy
// of the server table, works out the response to each action and compares
// every accepted output transaction with the oldest pending response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlcs_result_monitor
  import wlcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [3:0]  server_index_i,
  input  logic [5:0]  status_flags_i,
  input  logic [7:0]  replication_depth_i,
  input  logic [9:0]  weight_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        found_i,
  input  logic [3:0]  chosen_index_i,
  input  logic [15:0] connection_count_i,
  output int          pending_o,
  output int          errors_o
);

  localparam int unsigned NumServers = 16;
  localparam int unsigned PerMille   = 1000;

  typedef struct packed {
    logic              found;
    logic [3:0]        index;
    logic [CountW-1:0] count;
  } response_t;

  logic [CfgW-1:0]    filt_mask, filt_value;
  logic [NumW-1:0]    table_size;
  logic [CountW-1:0]  open_conns [NumServers];
  logic [LifeW-1:0]   total_conns[NumServers];
  logic [StatW-1:0]   srv_status [NumServers];
  logic [DepthW-1:0]  srv_depth  [NumServers];
  logic [WeightW-1:0] srv_weight [NumServers];
  response_t          expected_responses[$];

  assign pending_o = expected_responses.size();

  function automatic int unsigned server_load(int i);
    return ((int'(open_conns[i]) + 1) * PerMille) / int'(srv_weight[i]);
  endfunction

  function automatic int pick_server();
    int unsigned n;
    logic [StatW-1:0] mask, value, st;
    int root, best;
    int unsigned li, lb;
    n = (table_size > NumServers) ? NumServers : table_size;
    mask = filt_mask;
    value = filt_value;
    root = -1;
    best = -1;
    if (mask == 0 && value == 0) begin
      mask = StRunning;
      value = StRunning;
    end
    for (int i = 0; i < n; i++) begin
      if ((srv_status[i] & (StMaster | StMaint)) == StMaster &&
          (root < 0 || srv_depth[i] < srv_depth[root])) root = i;
    end
    for (int i = 0; i < n; i++) begin
      st = srv_status[i];
      if ((st & StMaint) != 0 || srv_weight[i] == 0) continue;
      if ((st & StRunning) == 0 || (st & mask & value) == 0) continue;
      if (root >= 0) begin
        if (i == root && (value & StSlave) != 0) continue;
        if (i == root && (value & StMaster) != 0) begin
          best = root;
          break;
        end
      end else if ((value & StMaster) != 0) begin
        best = -1;
        break;
      end
      if (best < 0) begin
        best = i;
      end else begin
        li = server_load(i);
        lb = server_load(best);
        if (li < lb || (li == lb && total_conns[i] < total_conns[best])) best = i;
      end
    end
    if (best < 0) best = root;
    return best;
  endfunction

  function automatic response_t apply_action(action_e act, int idx, logic [StatW-1:0] st,
                                             logic [DepthW-1:0] dep, logic [WeightW-1:0] wt);
    response_t r;
    int c;
    r = '{found: 1'b0, index: idx[3:0], count: '0};
    case (act)
      ActOpen: begin
        c = pick_server();
        r.index = '0;
        if (c >= 0) begin
          if (open_conns[c] != '1) open_conns[c]++;
          total_conns[c]++;
          r = '{found: 1'b1, index: c[3:0], count: open_conns[c]};
        end
      end
      ActLoad: begin
        srv_status[idx] = st;
        srv_depth[idx] = dep;
        srv_weight[idx] = wt;
        r.found = 1'b1;
        r.count = open_conns[idx];
      end
      ActClose: begin
        if (open_conns[idx] != 0) open_conns[idx]--;
        r.found = 1'b1;
        r.count = open_conns[idx];
      end
      default: r.count = open_conns[idx];
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    response_t want;
    if (!rst_ni) begin
      filt_mask = 6'd1;
      filt_value = 6'd1;
      table_size = '0;
      for (int i = 0; i < NumServers; i++) begin
        open_conns[i] = '0;
        total_conns[i] = '0;
        srv_status[i] = '0;
        srv_depth[i] = '0;
        srv_weight[i] = WeightReset;
      end
      expected_responses.delete();
      errors_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected response found=%0d index=%0d count=%0d", $time,
                   found_i, chosen_index_i, connection_count_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_responses.pop_front();
          if (found_i !== want.found || chosen_index_i !== want.index ||
              connection_count_i !== want.count) begin
            $display("%0t: mismatch expected found=%0d index=%0d count=%0d, got found=%0d index=%0d count=%0d",
                     $time, want.found, want.index, want.count,
                     found_i, chosen_index_i, connection_count_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgMask:  filt_mask = cfg_data_i;
          CfgValue: filt_value = cfg_data_i;
          CfgCount: table_size = cfg_data_i[NumW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_responses.push_back(apply_action(action_e'(action_i), int'(server_index_i),
                                                  status_flags_i, replication_depth_i,
                                                  weight_i));
    end
  end

endmodule

### tb/weighted_least_conn_selector_tb.sv
// ----------------------------------------------------------------------------
// weighted_least_conn_selector_tb: selector testbench
// Drives load, open, close and no-op transactions through several filter
// and table size settings, with random gaps and output back-pressure; the
// result monitor checks every response and counts the failures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_least_conn_selector_tb;
  import wlcs_pkg::*;

  localparam int StallLimit = 20000;
  localparam int NumPhases  = 9;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [5:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [3:0]  server_index_i = '0;
  logic [5:0]  status_flags_i = '0;
  logic [7:0]  replication_depth_i = '0;
  logic [9:0]  weight_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        found_o;
  logic [3:0]  chosen_index_o;
  logic [15:0] connection_count_o;
  int          pending, errors, quiet_cycles;
  bit          no_gaps = 1'b0;

  always #2 clk_i = ~clk_i;

  weighted_least_conn_selector u_dut (.*);

  wlcs_result_monitor u_monitor (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .server_index_i,
    .status_flags_i, .replication_depth_i, .weight_i,
    .out_valid_i(out_valid_o), .out_stall_i, .found_i(found_o),
    .chosen_index_i(chosen_index_o), .connection_count_i(connection_count_o),
    .pending_o(pending), .errors_o(errors)
  );

  always @(negedge clk_i) out_stall_i <= !no_gaps && ($urandom_range(0, 99) < 15);

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [5:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send(action_e act, logic [3:0] idx, logic [5:0] st = '0,
                      logic [7:0] dep = '0, logic [9:0] wt = '0);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(0, 99) < 15) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i = act;
    server_index_i = idx;
    status_flags_i = st;
    replication_depth_i = dep;
    weight_i = wt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_action();
    int roll;
    logic [5:0] st;
    logic [9:0] wt;
    roll = $urandom_range(0, 99);
    st = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 3) != 0) st[0] = 1'b1;
    if ($urandom_range(0, 5) != 0) st[3] = 1'b0;
    case ($urandom_range(0, 9))
      0:       wt = 10'd0;
      1:       wt = 10'd1000;
      2:       wt = 10'd511;
      default: wt = 10'($urandom_range(1, 1000));
    endcase
    if (roll < 30) send(ActLoad, 4'($urandom_range(0, 15)), st,
                        8'($urandom_range(0, 255)), wt);
    else if (roll < 75) send(ActOpen, 4'($urandom_range(0, 15)));
    else if (roll < 95) send(ActClose, 4'($urandom_range(0, 15)));
    else send(ActNone, 4'($urandom_range(0, 15)));
  endtask

  initial begin
    logic [5:0] m, v;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty filter, full table
    write_reg(CfgMask, 6'd0);
    write_reg(CfgValue, 6'd0);
    write_reg(CfgCount, 6'd16);
    send(ActOpen, 4'd3);
    send(ActLoad, 4'd0, StRunning | StMaster, 8'd255, 10'd1000);
    send(ActLoad, 4'd15, 6'h3F, 8'd0, 10'd0);
    send(ActLoad, 4'd5, StRunning | StSlave, 8'd0, 10'd1);
    send(ActLoad, 4'd7, StRunning | StMaster | 6'h30, 8'd0, 10'd511);
    send(ActLoad, 4'd9, StRunning, 8'd128, 10'd0);
    send(ActOpen, 4'd0);
    send(ActOpen, 4'd15);
    send(ActOpen, 4'd0);
    send(ActClose, 4'd9);
    send(ActClose, 4'd5);
    send(ActNone, 4'd7);
    send(ActNone, 4'd12);
    drain();
    // master filter, then slave filter
    write_reg(CfgMask, 6'h3F);
    write_reg(CfgValue, StMaster | StRunning);
    send(ActOpen, 4'd0);
    send(ActOpen, 4'd0);
    drain();
    write_reg(CfgValue, StSlave | StRunning);
    send(ActOpen, 4'd0);
    send(ActLoad, 4'd7, StMaint | StMaster | StRunning, 8'd3, 10'd10);
    send(ActOpen, 4'd0);
    drain();
    write_reg(CfgValue, StMaster);
    write_reg(CfgCount, 6'd31);
    send(ActOpen, 4'd0);
    send(ActLoad, 4'd0, StRunning, 8'd1, 10'd700);
    send(ActOpen, 4'd0);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 5)
        0: begin m = 6'd0; v = 6'd0; end
        1: begin m = 6'h3F; v = 6'h3F; end
        2: begin m = 6'd3; v = StMaster | StRunning; end
        3: begin m = 6'd5; v = StSlave | StRunning; end
        default: begin
          m = 6'($urandom_range(0, 63));
          v = 6'($urandom_range(0, 63));
        end
      endcase
      write_reg(CfgMask, m);
      write_reg(CfgValue, v);
      case (p % 4)
        0: write_reg(CfgCount, 6'd16);
        1: write_reg(CfgCount, 6'd1);
        2: write_reg(CfgCount, 6'($urandom_range(17, 31)));
        default: write_reg(CfgCount, 6'($urandom_range(0, 16)));
      endcase
      no_gaps = (p == 4);
      repeat (80) random_action();
      drain();
    end
    no_gaps = 1'b0;

    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/wlcs_pkg.sv
rtl/weighted_least_conn_selector.sv
rtl/wlcs_checker.sv
tb/wlcs_result_monitor.sv
tb/weighted_least_conn_selector_tb.sv
